// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants, widths and beat types for the line sensor centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

	localparam int NUM_PROBES = 16;
	localparam int FRAC_BITS  = 8;

	localparam int NUM_WORDS  = 8;
	localparam int WORD_W     = 16;
	localparam int PROBE_W    = 8;
	localparam int POS_W      = 15;

	// probes that both exist in the scan and are enabled
	localparam int PROBES_USED = (NUM_PROBES < 2 * NUM_WORDS) ? NUM_PROBES : 2 * NUM_WORDS;

	localparam int PROBE_MAX = (1 << PROBE_W) - 1;
	localparam int SUM_W     = $clog2(PROBES_USED * PROBE_MAX + 1);
	localparam int WGT_W     = $clog2((PROBES_USED * (PROBES_USED - 1) / 2) * PROBE_MAX + 1);
	localparam int Q_W       = $clog2(((PROBES_USED - 1) << FRAC_BITS) + 1);
	localparam int DIV_W     = WGT_W + FRAC_BITS;
	localparam int IDX_W     = $clog2(NUM_WORDS);
	localparam int PRB_W     = $clog2(2 * NUM_WORDS);

	localparam logic [PRB_W:0] PROBE_LIM = (PRB_W + 1)'(PROBES_USED);

	localparam int NO_LINE_CODE = 100;
	localparam logic [POS_W-1:0] NO_LINE_POS = POS_W'(NO_LINE_CODE << FRAC_BITS);

	localparam int NOISE_FLOOR_RESET = 5;

	// register map
	localparam int ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_NOISE_FLOOR = 2'd0;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

	typedef struct packed {
		logic [WORD_W-1:0] word0;
		logic [WORD_W-1:0] word1;
		logic [WORD_W-1:0] word2;
		logic [WORD_W-1:0] word3;
		logic [WORD_W-1:0] word4;
		logic [WORD_W-1:0] word5;
		logic [WORD_W-1:0] word6;
		logic [WORD_W-1:0] word7;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             line_found;
	} out_t;

	// accumulator chain payload: words not yet consumed sit at the bottom
	typedef struct packed {
		words_t           words;
		logic [WGT_W-1:0] wgt;
		logic [SUM_W-1:0] sum;
	} acc_t;

	// divider chain payload
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [Q_W-1:0]   low;
		logic [Q_W-1:0]   quo;
		logic [SUM_W-1:0] dvs;
		logic             found;
	} div_t;

endpackage

`default_nettype wire

// ===== rtl/lsc_acc_cell.sv =====
// ----------------------------------------------------------------------------
// lsc_acc_cell
// One accumulator cell: thresholds the two probes of the bottom word and adds
// them into the running weighted and plain sums.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_acc_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [lsc_pkg::IDX_W-1:0]  idx,
	input  wire logic [lsc_pkg::PROBE_W-1:0] noise_floor,
	input  wire logic                       up_valid,
	output logic                            up_ready,
	input  wire lsc_pkg::acc_t              up_data,
	output logic                            dn_valid,
	input  wire logic                       dn_ready,
	output lsc_pkg::acc_t                   dn_data
);

	logic                          valid_q;
	lsc_pkg::acc_t                 data_q;
	lsc_pkg::acc_t                 nxt;
	logic [lsc_pkg::WORD_W-1:0]    word;
	logic [lsc_pkg::PROBE_W-1:0]   v0;
	logic [lsc_pkg::PROBE_W-1:0]   v1;
	logic [lsc_pkg::PRB_W-1:0]     k0;
	logic [lsc_pkg::PRB_W-1:0]     k1;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		word = up_data.words[0];
		k0   = {idx, 1'b0};
		k1   = {idx, 1'b1};
		v0   = (word[lsc_pkg::PROBE_W-1:0] > noise_floor &&
			{1'b0, k0} < lsc_pkg::PROBE_LIM) ? word[lsc_pkg::PROBE_W-1:0] : '0;
		v1   = (word[lsc_pkg::WORD_W-1:lsc_pkg::PROBE_W] > noise_floor &&
			{1'b0, k1} < lsc_pkg::PROBE_LIM) ? word[lsc_pkg::WORD_W-1:lsc_pkg::PROBE_W] : '0;

		nxt.words = {{lsc_pkg::WORD_W{1'b0}}, up_data.words[lsc_pkg::NUM_WORDS-1:1]};
		nxt.wgt   = up_data.wgt
			+ lsc_pkg::WGT_W'(k0) * lsc_pkg::WGT_W'(v0)
			+ lsc_pkg::WGT_W'(k1) * lsc_pkg::WGT_W'(v1);
		nxt.sum   = up_data.sum
			+ lsc_pkg::SUM_W'(v0)
			+ lsc_pkg::SUM_W'(v1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lsc_div_cell.sv =====
// ----------------------------------------------------------------------------
// lsc_div_cell
// One restoring-division cell: brings in the next dividend bit, subtracts the
// divisor when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire lsc_pkg::div_t up_data,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output lsc_pkg::div_t      dn_data
);

	logic                        valid_q;
	lsc_pkg::div_t               data_q;
	lsc_pkg::div_t               nxt;
	logic [lsc_pkg::SUM_W:0]     trial;
	logic [lsc_pkg::SUM_W:0]     diff;
	logic                        ge;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		trial = {up_data.rem, up_data.low[lsc_pkg::Q_W-1]};
		diff  = trial - {1'b0, up_data.dvs};
		ge    = trial >= {1'b0, up_data.dvs};

		nxt       = up_data;
		nxt.rem   = ge ? diff[lsc_pkg::SUM_W-1:0] : trial[lsc_pkg::SUM_W-1:0];
		nxt.low   = {up_data.low[lsc_pkg::Q_W-2:0], 1'b0};
		nxt.quo   = {up_data.quo[lsc_pkg::Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/line_sensor_centroid_top.sv =====
// ----------------------------------------------------------------------------
// line_sensor_centroid_top
// Weighted-centroid line position from one 16-probe scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one scan (eight words, two 8-bit probes each) and is
//   taken when in_valid is high and in_stall is low. out_data carries the
//   centroid in Q.8 and line_found; it is taken when out_valid is high and
//   out_stall is low. Each scan yields exactly one result beat.
//   Probes at or below noise_floor (APB register at address 0) count as zero.
//   Throughput: one scan per cycle while out_stall stays low. Each scan passes
//   through eight accumulator cells, one per input word, then twelve divider
//   cells, one per quotient bit, then the output register; the first cell
//   loads at the accepting edge.
//   Each cell has its own valid bit, so a stalled receiver only backs up the
//   chain once the cells behind the output register are full; empty cells
//   keep taking scans until then. in_stall rises once the whole chain is full.
//   When no probe survives the floor the result is 100.0 with line_found low.
//   Reset empties the chain and sets noise_floor to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_centroid_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lsc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire lsc_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output lsc_pkg::out_t                    out_data
);

	logic [lsc_pkg::PROBE_W-1:0] noise_floor_q;

	logic          acc_valid [lsc_pkg::NUM_WORDS+1];
	logic          acc_ready [lsc_pkg::NUM_WORDS+1];
	lsc_pkg::acc_t acc_data  [lsc_pkg::NUM_WORDS+1];

	logic          div_valid [lsc_pkg::Q_W+1];
	logic          div_ready [lsc_pkg::Q_W+1];
	lsc_pkg::div_t div_data  [lsc_pkg::Q_W+1];

	logic [lsc_pkg::DIV_W-1:0] dividend;
	logic                      out_valid_q;
	lsc_pkg::out_t             out_q;
	lsc_pkg::out_t             out_nxt;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == lsc_pkg::REG_NOISE_FLOOR) ? 32'(noise_floor_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_floor_q <= lsc_pkg::PROBE_W'(lsc_pkg::NOISE_FLOOR_RESET);
		end else if (psel && penable && pwrite && pready &&
			paddr == lsc_pkg::REG_NOISE_FLOOR) begin
			noise_floor_q <= pwdata[lsc_pkg::PROBE_W-1:0];
		end
	end

	// accumulator chain
	assign acc_valid[0]      = in_valid;
	assign in_stall          = !acc_ready[0];
	assign acc_data[0].words = {in_data.word7, in_data.word6, in_data.word5, in_data.word4,
		in_data.word3, in_data.word2, in_data.word1, in_data.word0};
	assign acc_data[0].wgt   = '0;
	assign acc_data[0].sum   = '0;

	for (genvar g = 0; g < lsc_pkg::NUM_WORDS; g++) begin : g_acc
		lsc_acc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (lsc_pkg::IDX_W'(g)),
			.noise_floor (noise_floor_q),
			.up_valid    (acc_valid[g]),
			.up_ready    (acc_ready[g]),
			.up_data     (acc_data[g]),
			.dn_valid    (acc_valid[g+1]),
			.dn_ready    (acc_ready[g+1]),
			.dn_data     (acc_data[g+1])
		);
	end

	// divider chain: quotient of (wgt << FRAC_BITS) / sum always fits Q_W bits
	assign dividend           = {acc_data[lsc_pkg::NUM_WORDS].wgt, {lsc_pkg::FRAC_BITS{1'b0}}};
	assign div_valid[0]       = acc_valid[lsc_pkg::NUM_WORDS];
	assign acc_ready[lsc_pkg::NUM_WORDS] = div_ready[0];
	assign div_data[0].rem    = lsc_pkg::SUM_W'(dividend >> lsc_pkg::Q_W);
	assign div_data[0].low    = dividend[lsc_pkg::Q_W-1:0];
	assign div_data[0].quo    = '0;
	assign div_data[0].dvs    = acc_data[lsc_pkg::NUM_WORDS].sum;
	assign div_data[0].found  = acc_data[lsc_pkg::NUM_WORDS].sum != '0;

	for (genvar g = 0; g < lsc_pkg::Q_W; g++) begin : g_div
		lsc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_valid[g]),
			.up_ready (div_ready[g]),
			.up_data  (div_data[g]),
			.dn_valid (div_valid[g+1]),
			.dn_ready (div_ready[g+1]),
			.dn_data  (div_data[g+1])
		);
	end

	// output register
	assign div_ready[lsc_pkg::Q_W] = !out_valid_q || !out_stall;

	always_comb begin
		out_nxt.line_found = div_data[lsc_pkg::Q_W].found;
		out_nxt.position   = div_data[lsc_pkg::Q_W].found ?
			lsc_pkg::POS_W'(div_data[lsc_pkg::Q_W].quo) : lsc_pkg::NO_LINE_POS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ready[lsc_pkg::Q_W]) begin
			out_valid_q <= div_valid[lsc_pkg::Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready[lsc_pkg::Q_W] && div_valid[lsc_pkg::Q_W]) begin
			out_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== verif/tb_line_sensor_centroid_top.sv =====
// ----------------------------------------------------------------------------
// tb_line_sensor_centroid_top
// Self-checking bench for the line sensor centroid block: scans go in through
// a queue-fed driver, a local predictor computes the thresholded centroid at
// each accepted beat, and a monitor checks every result beat in order.
// Phases cover several noise floors (both extremes), random idle and stall
// patterns, and a long receiver hold-off that backs the chain up to its input.
// ----------------------------------------------------------------------------
module tb_line_sensor_centroid_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY     = 21;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 300;

	logic                        clk     = 1'b0;
	logic                        arst_n  = 1'b0;
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [lsc_pkg::ADDR_W-1:0]  paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	lsc_pkg::in_t                in_data  = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	lsc_pkg::out_t               out_data;

	lsc_pkg::in_t  scan_q[$];
	lsc_pkg::out_t centroid_exp_q[$];
	logic [7:0]    noise_floor_cfg = 8'(lsc_pkg::NOISE_FLOOR_RESET);
	int            send_idle_pct   = 0;
	int            recv_stall_pct  = 0;
	int            fail_count      = 0;
	int            beats_out       = 0;
	int            hold_cnt        = 0;
	int            quiet_cycles    = 0;

	line_sensor_centroid_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// thresholded weighted centroid of one scan
	function automatic lsc_pkg::out_t predict_centroid(input lsc_pkg::in_t scan,
		input logic [7:0] floor_v);
		logic [15:0]   w [8];
		logic [7:0]    v;
		int unsigned   wsum;
		int unsigned   ssum;
		int unsigned   q;
		lsc_pkg::out_t r;
		w = '{scan.word0, scan.word1, scan.word2, scan.word3,
		      scan.word4, scan.word5, scan.word6, scan.word7};
		wsum = 0;
		ssum = 0;
		for (int k = 0; k < lsc_pkg::PROBES_USED; k++) begin
			v = (k % 2 != 0) ? w[k / 2][15:8] : w[k / 2][7:0];
			if (v > floor_v) begin
				wsum += k * v;
				ssum += v;
			end
		end
		if (ssum == 0) begin
			r.position   = lsc_pkg::POS_W'(lsc_pkg::NO_LINE_CODE << lsc_pkg::FRAC_BITS);
			r.line_found = 1'b0;
		end else begin
			q            = (wsum << lsc_pkg::FRAC_BITS) / ssum;
			r.position   = q[lsc_pkg::POS_W-1:0];
			r.line_found = 1'b1;
		end
		return r;
	endfunction

	function automatic lsc_pkg::in_t pack_probes(input logic [7:0] p [16]);
		lsc_pkg::in_t s;
		s.word0 = {p[1], p[0]};
		s.word1 = {p[3], p[2]};
		s.word2 = {p[5], p[4]};
		s.word3 = {p[7], p[6]};
		s.word4 = {p[9], p[8]};
		s.word5 = {p[11], p[10]};
		s.word6 = {p[13], p[12]};
		s.word7 = {p[15], p[14]};
		return s;
	endfunction

	// mostly line-shaped scans (a blob over sub-floor noise), some no-line
	// scans, and some fully random words
	function automatic lsc_pkg::in_t random_scan(input logic [7:0] floor_v);
		logic [7:0] p [16];
		int         kind;
		int         c;
		int         wd;
		kind = $urandom_range(9, 0);
		c    = $urandom_range(15, 0);
		wd   = $urandom_range(3, 0);
		for (int k = 0; k < 16; k++) begin
			if (kind < 2)
				p[k] = 8'($urandom);
			else if (kind >= 3 && k >= c && k <= c + wd)
				p[k] = 8'($urandom_range(255, 0));
			else
				p[k] = 8'($urandom_range(floor_v, 0));
		end
		return pack_probes(p);
	endfunction

	task automatic apb_write(input logic [lsc_pkg::ADDR_W-1:0] a, input logic [31:0] d);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == lsc_pkg::REG_NOISE_FLOOR)
			noise_floor_cfg = d[7:0];
	endtask

	task automatic apb_read_check(input logic [lsc_pkg::ADDR_W-1:0] a,
		input logic [31:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		// sample mid-cycle in the access phase
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (prdata !== want)
			flag_mismatch($sformatf("reg %0d read %0h, want %0h", a, prdata, want));
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_floor(input logic [7:0] f);
		apb_write(lsc_pkg::REG_NOISE_FLOOR, 32'(f));
		apb_read_check(lsc_pkg::REG_NOISE_FLOOR, 32'(f));
	endtask

	task automatic drain;
		while (scan_q.size() != 0 || in_valid || centroid_exp_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic add_random(input int n);
		repeat (n) scan_q.push_back(random_scan(noise_floor_cfg));
	endtask

	// driver: offer scans, predict at each accepted beat
	always @(posedge clk or negedge arst_n) begin : drive_scans
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				centroid_exp_q.push_back(predict_centroid(in_data, noise_floor_cfg));
			if (!in_valid || !in_stall) begin
				if (scan_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= scan_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check result beats, drive receiver stall
	always @(posedge clk or negedge arst_n) begin : check_results
		lsc_pkg::out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (centroid_exp_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat pos=%0d found=%0b",
						out_data.position, out_data.line_found));
				end else begin
					want = centroid_exp_q.pop_front();
					if (out_data.position !== want.position)
						flag_mismatch($sformatf("position %0d, want %0d",
							out_data.position, want.position));
					if (out_data.line_found !== want.line_found)
						flag_mismatch($sformatf("line_found %0b, want %0b",
							out_data.line_found, want.line_found));
				end
				beats_out++;
				// long hold-off so the chain fills and in_stall rises
				if (beats_out == HOLD_AT)
					hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] p [16];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read_check(lsc_pkg::REG_NOISE_FLOOR, 32'(lsc_pkg::NOISE_FLOOR_RESET));

		// directed scans at the reset floor
		foreach (p[k]) p[k] = 8'h00;
		scan_q.push_back(pack_probes(p));
		foreach (p[k]) p[k] = 8'hFF;
		scan_q.push_back(pack_probes(p));
		foreach (p[k]) p[k] = 8'(lsc_pkg::NOISE_FLOOR_RESET);      // all at floor: no line
		scan_q.push_back(pack_probes(p));
		foreach (p[k]) p[k] = 8'(lsc_pkg::NOISE_FLOOR_RESET + 1);  // just above floor
		scan_q.push_back(pack_probes(p));
		foreach (p[k]) p[k] = 8'h00;
		p[1] = 8'd200;
		p[2] = 8'd100;                                     // fraction truncates
		scan_q.push_back(pack_probes(p));
		for (int j = 0; j < 16; j++) begin
			foreach (p[k]) p[k] = 8'h00;
			p[j] = 8'(255 - 9 * j);
			scan_q.push_back(pack_probes(p));
		end
		drain();

		set_floor(8'd0);
		add_random(100);
		drain();

		set_floor(8'($urandom_range(254, 1)));
		send_idle_pct = 84;
		add_random(100);
		drain();

		set_floor(8'(lsc_pkg::NOISE_FLOOR_RESET));
		send_idle_pct  = 0;
		recv_stall_pct = 84;
		add_random(100);
		drain();

		set_floor(8'($urandom_range(254, 1)));
		send_idle_pct  = 34;
		recv_stall_pct = 34;
		add_random(100);
		drain();

		// top floor: every scan reads as no line
		set_floor(8'd255);
		add_random(20);
		drain();

		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0 && centroid_exp_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
